FILE: rtl/rs485_relay_command_decoder_defines.svh
// Assertion macros shared by the relay command decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RS485_RELAY_COMMAND_DECODER_DEFINES_SVH
`define RS485_RELAY_COMMAND_DECODER_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define RRCD_ASSERT_HOLDS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("rrcd assertion failed");

// A consequence that holds in the cycle after its antecedent.
`define RRCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rrcd assertion failed");

`endif

FILE: rtl/rrcd_pkg.sv
// Package for the RS-485 relay command decoder: constants, codes and the
// command record passed from the classifier to the executor. No dependencies.
`timescale 1ns / 1ps

package rrcd_pkg;

    localparam int FRAME_LEN       = 8;
    localparam int CRC_BYTES       = 6;
    localparam int CNT_W           = $clog2(FRAME_LEN + 1);
    localparam int FIDX_W          = $clog2(FRAME_LEN);
    localparam int RELAY_STATE_W   = 4;
    localparam int NUM_BUTTON_REGS = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int RELAY_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] CMD_TOGGLE   = 8'h03;
    localparam logic [7:0] TOGGLE_SUB   = 8'h02;
    localparam logic [7:0] CMD_EXPLICIT = 8'h47;
    localparam logic [7:0] CMD_ADDR_CFG = 8'h45;
    localparam logic [7:0] CMD_CONFIRM  = 8'h46;
    localparam logic [7:0] BTN_ALL      = 8'hFF;
    localparam logic [7:0] VAL_TOGGLE   = 8'hFF;
    localparam logic [7:0] VAL_ON       = 8'h01;

    typedef enum logic [2:0] {
        REG_NODE_ADDR     = 3'd0,
        REG_RELAY1_BUTTON = 3'd1,
        REG_RELAY2_BUTTON = 3'd2,
        REG_RELAY3_BUTTON = 3'd3,
        REG_RELAY4_BUTTON = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CLS_UNKNOWN  = 3'd0,
        CLS_TOGGLE   = 3'd1,
        CLS_EXPLICIT = 3'd2,
        CLS_ADDR_CFG = 3'd3,
        CLS_CONFIRM  = 3'd4
    } frame_class_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_BUTTON  = 3'd1,
        ACT_ALL_OFF = 3'd2,
        ACT_CAPTURE = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        MODE_TOGGLE = 2'd0,
        MODE_ON     = 2'd1,
        MODE_OFF    = 2'd2
    } mode_t;

    typedef struct packed {
        frame_class_t cls;
        logic         crc_ok;
        action_t      act;
        mode_t        mode;
        logic [7:0]   button;
        logic [7:0]   cap_id;
        logic [31:0]  cap_map;
    } rrcd_cmd_t;

endpackage

FILE: rtl/rs485_relay_command_decoder.sv
// RS-485 relay command decoder: usage notes below.
// Top level; depends on rrcd_pkg, rrcd_front, rrcd_queue and rrcd_back.
//
// The input channel carries either a received byte (s_func low) or an idle-gap
// event (s_func high). Bytes produce no result; each gap produces exactly one
// result on the m_ channel with the frame class, the CRC check and the relay
// and pending-mapping state after the frame has been executed.
// The configuration channel writes the keypad address and the four relay
// button mappings; it is always ready. The user must see that it is written
// only while the block is idle; the block itself does not enforce this.
// Throughput is one input item per cycle while s_ready is high; the CRC update
// and the frame compare in the front end are combinational. Each gap command is
// queued, then the executor loads its result into the output register.
// When the receiver stalls, the result is held, further commands wait in the
// queue, and s_ready drops only once the queue is full.
// Reset clears the byte count, the CRC, the relays, the pending mapping and
// all configuration registers; no clearing pass is needed.
`timescale 1ns / 1ps

module rs485_relay_command_decoder import rrcd_pkg::*; #(
    parameter int RELAY_COUNT = RELAY_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [7:0]               s_rx_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [RELAY_STATE_W-1:0] m_relay_state,
    output logic [2:0]               m_frame_class,
    output logic                     m_crc_ok,
    output logic                     m_relays_changed,
    output logic                     m_last_on_off,
    output logic                     m_config_pending,
    output logic [7:0]               m_pending_keypad,
    output logic [31:0]              m_pending_buttons,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]               cfg_data
);

    logic [7:0]                  node_addr_reg;
    logic [RELAY_COUNT-1:0][7:0] button_reg;
    logic                        cfg_write;
    logic                        front_cmd_valid;
    rrcd_cmd_t                   front_cmd;
    logic                        q_valid;
    logic                        q_ready;
    rrcd_cmd_t                   q_cmd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_addr_reg <= 8'd0;
        end else if (cfg_write && (cfg_index == REG_NODE_ADDR)) begin
            node_addr_reg <= cfg_data;
        end
    end

    for (genvar g = 0; g < RELAY_COUNT; g++) begin : g_button
        if (g < NUM_BUTTON_REGS) begin : g_reg
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    button_reg[g] <= 8'd0;
                end else if (cfg_write &&
                             (cfg_index == CFG_IDX_W'(int'(REG_RELAY1_BUTTON) + g))) begin
                    button_reg[g] <= cfg_data;
                end
            end
        end else begin : g_none
            assign button_reg[g] = 8'd0;
        end
    end

    rrcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .node_addr (node_addr_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_byte   (s_rx_byte),
        .cmd_valid (front_cmd_valid),
        .cmd       (front_cmd)
    );

    rrcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_cmd_valid),
        .push_ready (s_ready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    rrcd_back #(
        .RELAY_COUNT (RELAY_COUNT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .relay_buttons   (button_reg),
        .cmd_valid       (q_valid),
        .cmd_ready       (q_ready),
        .cmd             (q_cmd),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .relay_state     (m_relay_state),
        .frame_class     (m_frame_class),
        .crc_ok          (m_crc_ok),
        .relays_changed  (m_relays_changed),
        .last_on_off     (m_last_on_off),
        .config_pending  (m_config_pending),
        .pending_keypad  (m_pending_keypad),
        .pending_buttons (m_pending_buttons)
    );

endmodule

FILE: rtl/rrcd_front.sv
// Front end of the relay command decoder: collects frame bytes, runs the
// CRC-16 and classifies each frame into a command. Depends on rrcd_pkg.
`timescale 1ns / 1ps

module rrcd_front import rrcd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] node_addr,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       in_func,
    input  logic [7:0] in_byte,
    output logic       cmd_valid,
    output rrcd_cmd_t  cmd
);

    logic [7:0]       store_reg [FRAME_LEN];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      crc_byte;
    logic             accept;
    logic             full;
    logic             ok;
    logic             is_toggle;
    logic             is_explicit;
    logic             is_addr_cfg;
    logic             is_confirm;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] onehot_button(input logic [7:0] v);
        logic [7:0] btn;
        btn = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (v == (8'd1 << i)) begin
                btn = 8'(i + 1);
            end
        end
        return btn;
    endfunction

    assign accept   = in_valid && in_ready;
    assign crc_byte = crc_step(crc_reg, in_byte);
    assign full     = (count_reg == CNT_W'(FRAME_LEN));

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (accept) begin
            if (in_func) begin
                count_next = '0;
                crc_next   = CRC_INIT;
            end else if (count_reg < CNT_W'(FRAME_LEN)) begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg < CNT_W'(CRC_BYTES)) begin
                    crc_next = crc_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !in_func && (count_reg < CNT_W'(FRAME_LEN))) begin
            store_reg[count_reg[FIDX_W-1:0]] <= in_byte;
        end
    end

    assign ok = full && (store_reg[6] == crc_reg[7:0]) && (store_reg[7] == crc_reg[15:8]);
    assign is_toggle = (store_reg[0] == node_addr) && (store_reg[1] == CMD_TOGGLE) &&
                       (store_reg[3] == TOGGLE_SUB);
    assign is_explicit = (store_reg[0] == node_addr) && (store_reg[1] == CMD_EXPLICIT) &&
                         (store_reg[5] == CMD_EXPLICIT);
    assign is_addr_cfg = (store_reg[1] == CMD_ADDR_CFG);
    assign is_confirm = (store_reg[1] == CMD_CONFIRM) && (store_reg[2] == CMD_CONFIRM) &&
                        (store_reg[3] == CMD_CONFIRM) && (store_reg[4] == CMD_CONFIRM) &&
                        (store_reg[5] != 8'h00);

    assign cmd_valid = accept && in_func;

    always_comb begin
        cmd.cls     = CLS_UNKNOWN;
        cmd.crc_ok  = ok;
        cmd.act     = ACT_NONE;
        cmd.mode    = MODE_TOGGLE;
        cmd.button  = store_reg[3];
        cmd.cap_id  = store_reg[0];
        cmd.cap_map = {store_reg[5], store_reg[4], store_reg[3], store_reg[2]};
        if (full) begin
            if (is_toggle) begin
                cmd.cls    = CLS_TOGGLE;
                cmd.act    = ACT_BUTTON;
                cmd.button = onehot_button(store_reg[5]);
            end else if (is_explicit) begin
                cmd.cls = CLS_EXPLICIT;
                if (store_reg[3] == BTN_ALL) begin
                    cmd.act = ACT_ALL_OFF;
                end else begin
                    cmd.act = ACT_BUTTON;
                    if (store_reg[4] == VAL_TOGGLE) begin
                        cmd.mode = MODE_TOGGLE;
                    end else if (store_reg[4] == VAL_ON) begin
                        cmd.mode = MODE_ON;
                    end else begin
                        cmd.mode = MODE_OFF;
                    end
                end
            end else if (is_addr_cfg) begin
                cmd.cls = CLS_ADDR_CFG;
                cmd.act = ACT_CAPTURE;
            end else if (is_confirm) begin
                cmd.cls = CLS_CONFIRM;
                cmd.act = ACT_CLEAR;
            end
        end
        if (!ok) begin
            cmd.act = ACT_NONE;
        end
    end

endmodule

FILE: rtl/rrcd_queue.sv
// Short command queue between the frame classifier and the executor.
// Depends on rrcd_pkg for the command record and on the assertion macro header.
`timescale 1ns / 1ps
`include "rs485_relay_command_decoder_defines.svh"

module rrcd_queue import rrcd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  rrcd_cmd_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output rrcd_cmd_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(DEPTH + 1);

    rrcd_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `RRCD_ASSERT_HOLDS(a_count_bound, aclk, aresetn, count_reg <= QCNT_W'(DEPTH))
    `RRCD_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1))
    `RRCD_ASSERT_NEXT(a_count_down, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - QCNT_W'(1))
    `RRCD_ASSERT_NEXT(a_ptr_hold, aclk, aresetn, !push && !pop, (wr_ptr_reg == $past(wr_ptr_reg)) && (rd_ptr_reg == $past(rd_ptr_reg)))

endmodule

FILE: rtl/rrcd_back.sv
// Back end of the relay command decoder: executes queued commands on the
// relay and pending-mapping state and holds the result register. Depends on rrcd_pkg.
`timescale 1ns / 1ps

module rrcd_back import rrcd_pkg::*; #(
    parameter int RELAY_COUNT = RELAY_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [RELAY_COUNT-1:0][7:0] relay_buttons,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  rrcd_cmd_t                   cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [RELAY_STATE_W-1:0]    relay_state,
    output logic [2:0]                  frame_class,
    output logic                        crc_ok,
    output logic                        relays_changed,
    output logic                        last_on_off,
    output logic                        config_pending,
    output logic [7:0]                  pending_keypad,
    output logic [31:0]                 pending_buttons
);

    logic                                 out_valid_reg;
    logic [RELAY_COUNT-1:0]               relay_reg;
    logic [RELAY_COUNT-1:0]               relay_next;
    logic                                 on_off_reg;
    logic                                 on_off_next;
    logic                                 pend_flag_reg;
    logic                                 pend_flag_next;
    logic [7:0]                           pend_id_reg;
    logic [7:0]                           pend_id_next;
    logic [31:0]                          pend_map_reg;
    logic [31:0]                          pend_map_next;
    logic [2:0]                           cls_reg;
    logic                                 ok_reg;
    logic                                 changed_reg;
    logic                                 changed_next;
    logic [RELAY_COUNT+RELAY_STATE_W-1:0] relay_wide;
    logic [RELAY_COUNT-1:0]               mask;
    logic                                 hit;
    logic                                 cur;
    logic                                 want;
    logic                                 fire;

    assign cmd_ready  = !out_valid_reg || out_ready;
    assign fire       = cmd_valid && cmd_ready;
    assign relay_wide = {{RELAY_STATE_W{1'b0}}, relay_reg};

    always_comb begin
        hit  = 1'b0;
        mask = '0;
        for (int i = 0; i < RELAY_COUNT; i++) begin
            if (!hit && (relay_buttons[i] == cmd.button)) begin
                hit     = 1'b1;
                mask[i] = 1'b1;
            end
        end
    end

    assign cur = |(relay_reg & mask);

    always_comb begin
        case (cmd.mode)
            MODE_TOGGLE: want = !cur;
            MODE_ON:     want = 1'b1;
            default:     want = 1'b0;
        endcase
    end

    always_comb begin
        relay_next     = relay_reg;
        on_off_next    = on_off_reg;
        pend_flag_next = pend_flag_reg;
        pend_id_next   = pend_id_reg;
        pend_map_next  = pend_map_reg;
        changed_next   = 1'b0;
        unique case (cmd.act)
            ACT_BUTTON: begin
                if (hit && (want != cur)) begin
                    relay_next   = want ? (relay_reg | mask) : (relay_reg & ~mask);
                    on_off_next  = want;
                    changed_next = 1'b1;
                end
            end
            ACT_ALL_OFF: begin
                changed_next = |relay_wide[RELAY_STATE_W-1:0];
                relay_next   = '0;
                on_off_next  = 1'b0;
            end
            ACT_CAPTURE: begin
                pend_id_next   = cmd.cap_id;
                pend_map_next  = cmd.cap_map;
                pend_flag_next = 1'b1;
            end
            ACT_CLEAR: begin
                pend_flag_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            relay_reg     <= '0;
            on_off_reg    <= 1'b0;
            pend_flag_reg <= 1'b0;
            pend_id_reg   <= 8'd0;
            pend_map_reg  <= 32'd0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
            relay_reg     <= relay_next;
            on_off_reg    <= on_off_next;
            pend_flag_reg <= pend_flag_next;
            pend_id_reg   <= pend_id_next;
            pend_map_reg  <= pend_map_next;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            cls_reg     <= cmd.cls;
            ok_reg      <= cmd.crc_ok;
            changed_reg <= changed_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign relay_state     = relay_wide[RELAY_STATE_W-1:0];
    assign frame_class     = cls_reg;
    assign crc_ok          = ok_reg;
    assign relays_changed  = changed_reg;
    assign last_on_off     = on_off_reg;
    assign config_pending  = pend_flag_reg;
    assign pending_keypad  = pend_id_reg;
    assign pending_buttons = pend_map_reg;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for rs485_relay_command_decoder: frames of bytes and
// idle gaps go in, every gap result is compared against a local decoder model.
// Depends on rrcd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_top;
    import rrcd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 8;

    typedef logic [5:0][7:0] frame_hdr_t;

    typedef struct packed {
        logic [3:0]   relays;
        frame_class_t cls;
        logic         crc_ok;
        logic         changed;
        logic         on_off;
        logic         pending;
        logic [7:0]   pend_id;
        logic [31:0]  pend_map;
    } relay_report_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_func = 1'b0;
    logic [7:0]               s_rx_byte = 8'h00;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [RELAY_STATE_W-1:0] m_relay_state;
    logic [2:0]               m_frame_class;
    logic                     m_crc_ok;
    logic                     m_relays_changed;
    logic                     m_last_on_off;
    logic                     m_config_pending;
    logic [7:0]               m_pending_keypad;
    logic [31:0]              m_pending_buttons;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [7:0]               cfg_data = 8'h00;

    // Decoder model state and its copy of the registers.
    logic [7:0]  frame_bytes [8];
    logic [3:0]  byte_total;
    logic [15:0] crc_run;
    logic [3:0]  relays;
    logic        on_off;
    logic        pend_flag;
    logic [7:0]  pend_id;
    logic [31:0] pend_map;
    logic [7:0]  keypad;
    logic [7:0]  btn_map [4];

    relay_report_t awaited_reports [$];
    relay_report_t report_due;

    int errors = 0;
    int items_sent = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    rs485_relay_command_decoder dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relay_state     (m_relay_state),
        .m_frame_class     (m_frame_class),
        .m_crc_ok          (m_crc_ok),
        .m_relays_changed  (m_relays_changed),
        .m_last_on_off     (m_last_on_off),
        .m_config_pending  (m_config_pending),
        .m_pending_keypad  (m_pending_keypad),
        .m_pending_buttons (m_pending_buttons),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] onehot_button(logic [7:0] v);
        for (int i = 0; i < 8; i++) begin
            if (v == 8'(1 << i)) return 8'(i + 1);
        end
        return 8'h00;
    endfunction

    function automatic logic press_button(logic [7:0] button, mode_t mode);
        logic cur;
        logic want;
        for (int i = 0; i < 4; i++) begin
            if (btn_map[i] == button) begin
                cur = relays[i];
                if (mode == MODE_TOGGLE) want = ~cur;
                else want = (mode == MODE_ON);
                if (want == cur) return 1'b0;
                relays[i] = want;
                on_off = want;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic clear_model();
        byte_total = 4'd0;
        crc_run = CRC_INIT;
        relays = 4'h0;
        on_off = 1'b0;
        pend_flag = 1'b0;
        pend_id = 8'h00;
        pend_map = 32'h0;
        keypad = 8'h00;
        for (int i = 0; i < 4; i++) btn_map[i] = 8'h00;
        for (int i = 0; i < 8; i++) frame_bytes[i] = 8'h00;
    endtask

    task automatic update_relay_model(input logic f, input logic [7:0] b);
        relay_report_t r;
        frame_class_t cls;
        logic ok;
        logic chg;
        mode_t mode;
        if (!f) begin
            if (byte_total < 4'd8) begin
                frame_bytes[byte_total[2:0]] = b;
                if (byte_total < 4'd6) crc_run = crc_byte(crc_run, b);
                byte_total = byte_total + 4'd1;
            end
        end else begin
            cls = CLS_UNKNOWN;
            ok = 1'b0;
            chg = 1'b0;
            if (byte_total == 4'd8) begin
                ok = (frame_bytes[6] == crc_run[7:0]) && (frame_bytes[7] == crc_run[15:8]);
                if (frame_bytes[0] == keypad && frame_bytes[1] == CMD_TOGGLE &&
                    frame_bytes[3] == TOGGLE_SUB) begin
                    cls = CLS_TOGGLE;
                    if (ok) chg = press_button(onehot_button(frame_bytes[5]), MODE_TOGGLE);
                end else if (frame_bytes[0] == keypad && frame_bytes[1] == CMD_EXPLICIT &&
                             frame_bytes[5] == CMD_EXPLICIT) begin
                    cls = CLS_EXPLICIT;
                    if (ok) begin
                        if (frame_bytes[3] == BTN_ALL) begin
                            chg = |relays;
                            relays = 4'h0;
                            on_off = 1'b0;
                        end else begin
                            if (frame_bytes[4] == VAL_TOGGLE) mode = MODE_TOGGLE;
                            else if (frame_bytes[4] == VAL_ON) mode = MODE_ON;
                            else mode = MODE_OFF;
                            chg = press_button(frame_bytes[3], mode);
                        end
                    end
                end else if (frame_bytes[1] == CMD_ADDR_CFG) begin
                    cls = CLS_ADDR_CFG;
                    if (ok) begin
                        pend_id = frame_bytes[0];
                        pend_map = {frame_bytes[5], frame_bytes[4], frame_bytes[3],
                                    frame_bytes[2]};
                        pend_flag = 1'b1;
                    end
                end else if (frame_bytes[1] == CMD_CONFIRM && frame_bytes[2] == CMD_CONFIRM &&
                             frame_bytes[3] == CMD_CONFIRM && frame_bytes[4] == CMD_CONFIRM &&
                             frame_bytes[5] != 8'h00) begin
                    cls = CLS_CONFIRM;
                    if (ok) pend_flag = 1'b0;
                end
            end
            byte_total = 4'd0;
            crc_run = CRC_INIT;
            r.relays = relays;
            r.cls = cls;
            r.crc_ok = ok;
            r.changed = chg;
            r.on_off = on_off;
            r.pending = pend_flag;
            r.pend_id = pend_id;
            r.pend_map = pend_map;
            awaited_reports.push_back(r);
        end
    endtask

    task automatic send_item(input logic f, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        update_relay_model(f, b);
        items_sent++;
    endtask

    function automatic frame_hdr_t make_hdr(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3, logic [7:0] b4, logic [7:0] b5);
        frame_hdr_t h;
        h[0] = b0;
        h[1] = b1;
        h[2] = b2;
        h[3] = b3;
        h[4] = b4;
        h[5] = b5;
        return h;
    endfunction

    // Sends nbytes of the frame (CRC appended, random filler past eight), then a gap.
    task automatic send_frame(input frame_hdr_t h, input bit crc_good, input int nbytes);
        logic [15:0] c;
        logic [7:0]  b;
        c = CRC_INIT;
        for (int i = 0; i < 6; i++) c = crc_byte(c, h[i]);
        if (!crc_good) c = c ^ 16'(1 << $urandom_range(0, 15));
        for (int i = 0; i < nbytes; i++) begin
            if (i < 6) b = h[i];
            else if (i == 6) b = c[7:0];
            else if (i == 7) b = c[15:8];
            else b = 8'($urandom);
            send_item(1'b0, b);
        end
        send_item(1'b1, 8'($urandom));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_NODE_ADDR:     keypad = d;
            REG_RELAY1_BUTTON: btn_map[0] = d;
            REG_RELAY2_BUTTON: btn_map[1] = d;
            REG_RELAY3_BUTTON: btn_map[2] = d;
            REG_RELAY4_BUTTON: btn_map[3] = d;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_regs(input logic [7:0] kid, input logic [7:0] r1, input logic [7:0] r2,
                             input logic [7:0] r3, input logic [7:0] r4);
        settle();
        write_reg(REG_NODE_ADDR, kid);
        write_reg(REG_RELAY1_BUTTON, r1);
        write_reg(REG_RELAY2_BUTTON, r2);
        write_reg(REG_RELAY3_BUTTON, r3);
        write_reg(REG_RELAY4_BUTTON, r4);
    endtask

    task automatic test_empty_and_short();
        send_item(1'b1, 8'h00);
        send_frame(make_hdr(8'h00, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'h00, 8'h01), 1'b1, 3);
        send_frame(make_hdr(8'h00, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'h00, 8'h01), 1'b1, 7);
    endtask

    task automatic test_toggle();
        load_regs(8'h5A, 8'd1, 8'd2, 8'd3, 8'd4);
        send_frame(make_hdr(8'h5A, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'hFF, 8'h01), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_TOGGLE, 8'hFF, TOGGLE_SUB, 8'h00, 8'h08), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_TOGGLE, 8'h12, TOGGLE_SUB, 8'h34, 8'h80), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_TOGGLE, 8'h12, TOGGLE_SUB, 8'h34, 8'h03), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'h00, 8'h02), 1'b0, 8);
        send_frame(make_hdr(8'hA5, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'h00, 8'h02), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'h00, 8'h01), 1'b1, 8);
    endtask

    task automatic test_explicit();
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, 8'd2, VAL_ON, CMD_EXPLICIT), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, 8'd2, VAL_ON, CMD_EXPLICIT), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, 8'd2, VAL_TOGGLE, CMD_EXPLICIT), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, 8'd3, VAL_ON, CMD_EXPLICIT), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, 8'd3, 8'h37, CMD_EXPLICIT), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, 8'd1, VAL_ON, CMD_EXPLICIT), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, BTN_ALL, 8'h00, CMD_EXPLICIT), 1'b1, 8);
        send_frame(make_hdr(8'h5A, CMD_EXPLICIT, 8'h00, BTN_ALL, 8'h00, CMD_EXPLICIT), 1'b1, 8);
    endtask

    task automatic test_addr_config();
        send_frame(make_hdr(8'hC3, CMD_ADDR_CFG, 8'h11, 8'h22, 8'h33, 8'h44), 1'b1, 8);
        send_frame(make_hdr(8'h3C, CMD_ADDR_CFG, 8'h55, 8'h66, 8'h77, 8'h88), 1'b0, 8);
        send_frame(make_hdr(8'h00, CMD_CONFIRM, CMD_CONFIRM, CMD_CONFIRM, CMD_CONFIRM, 8'h00),
                   1'b1, 8);
        send_frame(make_hdr(8'h00, CMD_CONFIRM, CMD_CONFIRM, CMD_CONFIRM, CMD_CONFIRM, 8'h01),
                   1'b1, 8);
    endtask

    task automatic test_long_frame();
        send_frame(make_hdr(8'h5A, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'h00, 8'h04), 1'b1, 12);
    endtask

    task automatic test_reg_extremes();
        load_regs(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80);
        send_frame(make_hdr(8'hFF, CMD_TOGGLE, 8'h00, TOGGLE_SUB, 8'h00, 8'h00), 1'b1, 8);
        send_frame(make_hdr(8'hFF, CMD_EXPLICIT, 8'h00, 8'h80, VAL_ON, CMD_EXPLICIT), 1'b1, 8);
        load_regs(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_frame(make_hdr(8'h00, CMD_TOGGLE, 8'hFF, TOGGLE_SUB, 8'hFF, 8'hFF), 1'b1, 8);
    endtask

    task automatic send_random_frame();
        logic [7:0] kid;
        logic [7:0] btn;
        logic [7:0] val;
        logic [7:0] b5;
        logic [7:0] cmd;
        bit good;
        int len;
        int pick;
        kid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : keypad;
        good = ($urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 19);
        if (pick == 0) len = $urandom_range(0, 7);
        else if (pick == 1) len = $urandom_range(9, 12);
        else len = 8;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                b5 = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
                send_frame(make_hdr(kid, CMD_TOGGLE, 8'($urandom), TOGGLE_SUB, 8'($urandom), b5),
                           good, len);
            end
            3, 4: begin
                case ($urandom_range(0, 5))
                    0: btn = BTN_ALL;
                    1: btn = 8'($urandom);
                    default: btn = btn_map[$urandom_range(0, 3)];
                endcase
                case ($urandom_range(0, 3))
                    0: val = VAL_TOGGLE;
                    1: val = VAL_ON;
                    2: val = 8'h00;
                    default: val = 8'($urandom);
                endcase
                send_frame(make_hdr(kid, CMD_EXPLICIT, 8'($urandom), btn, val, CMD_EXPLICIT),
                           good, len);
            end
            5: begin
                send_frame(make_hdr(8'($urandom), CMD_ADDR_CFG, 8'($urandom_range(0, 9)),
                                    8'($urandom_range(0, 9)), 8'($urandom), 8'($urandom)),
                           good, len);
            end
            6: begin
                b5 = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
                send_frame(make_hdr(8'($urandom), CMD_CONFIRM, CMD_CONFIRM, CMD_CONFIRM,
                                    CMD_CONFIRM, b5), good, len);
            end
            7: begin
                repeat ($urandom_range(1, 3)) send_item(1'b1, 8'($urandom));
            end
            8: begin
                case ($urandom_range(0, 4))
                    0: cmd = CMD_TOGGLE;
                    1: cmd = CMD_EXPLICIT;
                    2: cmd = CMD_CONFIRM;
                    default: cmd = 8'($urandom);
                endcase
                send_frame(make_hdr(kid, cmd, 8'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom)), good, len);
            end
            default: begin
                repeat ($urandom_range(0, 12)) send_item(1'b0, 8'($urandom));
                send_item(1'b1, 8'($urandom));
            end
        endcase
    endtask

    task automatic test_random_traffic(input int tx_idle, input int rx_idle, input int count);
        int stop_at;
        send_idle = tx_idle;
        recv_idle = rx_idle;
        stop_at = items_sent + count;
        while (items_sent < stop_at) send_random_frame();
    endtask

    task automatic test_output_stall();
        send_idle = 0;
        recv_idle = 0;
        hold_req = 1'b1;
        repeat (12) send_item(1'b1, 8'($urandom));
        repeat (6) send_random_frame();
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t unexpected result: expected none, actual class %0d",
                         $time, m_frame_class);
                errors++;
            end else begin
                report_due = awaited_reports.pop_front();
                check_field("relay_state", report_due.relays, m_relay_state);
                check_field("frame_class", report_due.cls, m_frame_class);
                check_field("crc_ok", report_due.crc_ok, m_crc_ok);
                check_field("relays_changed", report_due.changed, m_relays_changed);
                check_field("last_on_off", report_due.on_off, m_last_on_off);
                check_field("config_pending", report_due.pending, m_config_pending);
                check_field("pending_keypad", report_due.pend_id, m_pending_keypad);
                check_field("pending_buttons", report_due.pend_map, m_pending_buttons);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        clear_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_short();
        test_toggle();
        test_explicit();
        test_addr_config();
        test_long_frame();
        test_reg_extremes();
        load_regs(8'($urandom), 8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                  8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)));
        test_random_traffic(33, 80, 300);
        load_regs(8'hFF, 8'($urandom_range(1, 8)), 8'hFF, 8'($urandom_range(0, 8)), 8'h00);
        test_random_traffic(80, 33, 300);
        load_regs(8'h00, 8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                  8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)));
        test_output_stall();
        test_random_traffic(0, 0, 300);
        s_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && awaited_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
